@@ rtl/ers_pkg.sv @@
package ers_pkg;

    // configuration register widths
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned VEL_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // result field widths
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned BEAT_W = 22;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_COUNT   = 3'd0,
        REG_STEP_COUNT    = 3'd1,
        REG_STEP_LENGTH   = 3'd2,
        REG_BASE_VELOCITY = 3'd3,
        REG_JITTER_AMOUNT = 3'd4
    } t_cfg_reg;

    // opcodes
    localparam logic OP_REBUILD = 1'b0;
    localparam logic OP_PLAY    = 1'b1;

endpackage

@@ rtl/euclidean_rhythm_sequencer.sv @@
// Euclidean rhythm step sequencer.
// Input channel (i_valid/o_ready) carries an opcode and a random sample.
// A rebuild word lays out pulse_count hits over step_count steps with the
// Bjorklund group merge and rewinds to step 0; its result word is all zero.
// A play word reports the current step (hit, index, beat position, jittered
// velocity, last-step flag) and advances, wrapping after the last step.
// Output channel (o_valid/i_ready) holds one registered result word.
// Configuration port (i_cfg_valid/o_cfg_ready) is always ready; writes are
// expected only while the block is idle.
// One word is in flight at a time; o_ready is high only in the idle state.
// A play word passes from idle to the output state, which registers its result.
// A rebuild word passes through the init state and, unless the pattern is all
// rests or all hits, the merge and emit states before the output state: one merge
// per cycle, then one group copy per cycle; each merge drops the group count, so
// merges plus emits never pass step_count.
// If the receiver stalls, the previous result waits in the output register and
// the sequencer holds the new one in the output state before returning to idle.
// Reset clears the pattern to all rests, rewinds to step 0 and loads the
// register defaults: 4 hits, 16 steps, step length 0.25 beat, full velocity,
// no jitter.
module euclidean_rhythm_sequencer #(
    parameter int unsigned MAX_STEPS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic [7:0]                    i_random_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [ers_pkg::IDX_W-1:0]     o_step_index,
    output logic [ers_pkg::BEAT_W-1:0]    o_beat_position,
    output logic [ers_pkg::VEL_W-1:0]     o_velocity_out,
    output logic                          o_pattern_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ers_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ers_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ers_pkg::*;

    localparam int unsigned PW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int unsigned MW  = $clog2(MAX_STEPS + 1);
    localparam int unsigned EW  = (CNT_W > MW) ? CNT_W : MW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MERGE,
        ST_EMIT,
        ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [CNT_W-1:0] r_pulse_count;
    logic [CNT_W-1:0] r_step_count;
    logic [LEN_W-1:0] r_step_length;
    logic [VEL_W-1:0] r_base_velocity;
    logic [VEL_W-1:0] r_jitter_amount;

    // pattern and playback
    logic [MAX_STEPS-1:0] r_pattern;
    logic [PW-1:0]        r_play_pos;

    // latched input word
    logic       r_op;
    logic [7:0] r_rand;

    // build scratch: group A and group B with their lengths and counts
    logic [MAX_STEPS-1:0] r_grp_a;
    logic [MAX_STEPS-1:0] r_grp_b;
    logic [EW-1:0]        r_len_a;
    logic [EW-1:0]        r_len_b;
    logic [EW-1:0]        r_head_cnt;
    logic [EW-1:0]        r_tail_cnt;
    logic [EW-1:0]        r_guard;
    logic [EW-1:0]        r_emit_cnt;
    logic [EW-1:0]        r_emit_pos;

    logic [EW-1:0]        n_steps;
    logic [EW-1:0]        k_hits;
    logic [EW-1:0]        grp_min;
    logic [EW-1:0]        play_ext;
    logic                 play_hit;
    logic                 play_last;
    logic [PW+LEN_W-1:0]  beat_prod;
    logic signed [9:0]    rand_ctr;
    logic signed [18:0]   dev;
    logic signed [10:0]   vel_sum;
    logic [VEL_W-1:0]     vel_clamped;
    logic                 out_free;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign out_free    = !o_valid || i_ready;

    // effective step count: zero reads as one, saturates at the pattern size
    always_comb begin
        n_steps = (r_step_count == '0) ? EW'(1) : EW'(r_step_count);
        if (n_steps > EW'(MAX_STEPS)) begin
            n_steps = EW'(MAX_STEPS);
        end
    end

    assign k_hits  = EW'(r_pulse_count);
    assign grp_min = (r_head_cnt < r_tail_cnt) ? r_head_cnt : r_tail_cnt;

    // play datapath
    assign play_ext  = EW'(r_play_pos);
    assign play_hit  = (play_ext < n_steps) ? r_pattern[r_play_pos] : 1'b0;
    assign play_last = (play_ext + EW'(1)) >= n_steps;
    assign beat_prod = (PW+LEN_W)'(r_play_pos) * (PW+LEN_W)'(r_step_length);

    // deviation = floor((2r - 256) * jitter / 256)
    assign rand_ctr = $signed({1'b0, r_rand, 1'b0}) - 10'sd256;
    assign dev      = 19'(rand_ctr) * $signed({11'b0, r_jitter_amount});
    assign vel_sum  = $signed({3'b0, r_base_velocity}) + 11'(dev >>> 8);

    always_comb begin
        if (vel_sum < 0) begin
            vel_clamped = '0;
        end else if (vel_sum > 11'sd255) begin
            vel_clamped = '1;
        end else begin
            vel_clamped = vel_sum[VEL_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_count   <= CNT_W'(4);
            r_step_count    <= CNT_W'(16);
            r_step_length   <= LEN_W'(64);
            r_base_velocity <= VEL_W'(255);
            r_jitter_amount <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PULSE_COUNT:   r_pulse_count   <= i_cfg_data[CNT_W-1:0];
                REG_STEP_COUNT:    r_step_count    <= i_cfg_data[CNT_W-1:0];
                REG_STEP_LENGTH:   r_step_length   <= i_cfg_data[LEN_W-1:0];
                REG_BASE_VELOCITY: r_base_velocity <= i_cfg_data[VEL_W-1:0];
                REG_JITTER_AMOUNT: r_jitter_amount <= i_cfg_data[VEL_W-1:0];
                default: ;
            endcase
        end
    end

    // build scratch, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_INIT: begin
                r_grp_a    <= MAX_STEPS'(1);
                r_grp_b    <= '0;
                r_len_a    <= EW'(1);
                r_len_b    <= EW'(1);
                r_head_cnt <= k_hits;
                r_tail_cnt <= n_steps - k_hits;
                r_guard    <= '0;
                r_emit_cnt <= '0;
                r_emit_pos <= '0;
            end
            ST_MERGE: begin
                if (r_tail_cnt > EW'(1) && r_guard < EW'(MAX_STEPS)) begin
                    // append B to A; if A was the more numerous, old A becomes B
                    r_grp_a    <= r_grp_a | (r_grp_b << r_len_a);
                    r_len_a    <= r_len_a + r_len_b;
                    r_head_cnt <= grp_min;
                    r_guard    <= r_guard + EW'(1);
                    if (r_head_cnt > grp_min) begin
                        r_grp_b    <= r_grp_a;
                        r_len_b    <= r_len_a;
                        r_tail_cnt <= r_head_cnt - grp_min;
                    end else begin
                        r_tail_cnt <= r_tail_cnt - grp_min;
                    end
                end
            end
            ST_EMIT: begin
                if (r_emit_cnt < r_head_cnt) begin
                    r_emit_pos <= r_emit_pos + r_len_a;
                    r_emit_cnt <= r_emit_cnt + EW'(1);
                end else if (r_emit_cnt < r_head_cnt + r_tail_cnt) begin
                    r_emit_pos <= r_emit_pos + r_len_b;
                    r_emit_cnt <= r_emit_cnt + EW'(1);
                end
            end
            default: ;
        endcase
    end

    // sequencer, pattern, playback and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pattern  <= '0;
            r_play_pos <= '0;
            o_valid    <= 1'b0;
        end else begin
            // the output state reloads the word itself
            if (o_valid && i_ready && r_state != ST_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_opcode;
                        r_rand <= i_random_value;
                        r_state <= (i_opcode == OP_REBUILD) ? ST_INIT : ST_OUT;
                    end
                end
                ST_INIT: begin
                    if (k_hits == '0) begin
                        r_pattern <= '0;
                        r_state   <= ST_OUT;
                    end else if (k_hits >= n_steps) begin
                        r_pattern <= ~({MAX_STEPS{1'b1}} << n_steps);
                        r_state   <= ST_OUT;
                    end else begin
                        r_pattern <= '0;
                        r_state   <= ST_MERGE;
                    end
                end
                ST_MERGE: begin
                    if (!(r_tail_cnt > EW'(1) && r_guard < EW'(MAX_STEPS))) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // lay out head copies of A, then tail copies of B
                    if (r_emit_cnt < r_head_cnt) begin
                        r_pattern <= r_pattern | (r_grp_a << r_emit_pos);
                    end else if (r_emit_cnt < r_head_cnt + r_tail_cnt) begin
                        r_pattern <= r_pattern | (r_grp_b << r_emit_pos);
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        r_state <= ST_IDLE;
                        if (r_op == OP_PLAY) begin
                            o_hit           <= play_hit;
                            o_step_index    <= IDX_W'(r_play_pos);
                            o_beat_position <= BEAT_W'(beat_prod);
                            o_velocity_out  <= play_hit ? vel_clamped : '0;
                            o_pattern_end   <= play_last;
                            r_play_pos      <= play_last ? '0 : r_play_pos + PW'(1);
                        end else begin
                            o_hit           <= 1'b0;
                            o_step_index    <= '0;
                            o_beat_position <= '0;
                            o_velocity_out  <= '0;
                            o_pattern_end   <= 1'b0;
                            r_play_pos      <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ verif/euclidean_rhythm_sequencer_tb.sv @@
module euclidean_rhythm_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ers_pkg::*;

    localparam int STEP_CAP    = 64;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 80;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  index;
        logic [BEAT_W-1:0] beat;
        logic [VEL_W-1:0]  velocity;
        logic              last;
    } t_step_word;

    // tracks pattern, playback position and registers; queues the step words due out
    class t_rhythm_book;
        logic [CNT_W-1:0]    pulses;
        logic [CNT_W-1:0]    steps;
        logic [LEN_W-1:0]    step_len;
        logic [VEL_W-1:0]    base_vel;
        logic [VEL_W-1:0]    jitter;
        logic [STEP_CAP-1:0] pattern;
        bit                  built;
        int                  cursor;
        int                  errors;
        t_step_word          due[$];

        function new();
            pulses   = CNT_W'(4);
            steps    = CNT_W'(16);
            step_len = LEN_W'(64);
            base_vel = VEL_W'(255);
            jitter   = '0;
            pattern  = '0;
            built    = 0;
            cursor   = 0;
            errors   = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function int span();
            int n;
            n = int'(steps);
            if (n == 0) n = 1;
            if (n > STEP_CAP) n = STEP_CAP;
            return n;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PULSE_COUNT:   pulses   = data[CNT_W-1:0];
                REG_STEP_COUNT:    steps    = data[CNT_W-1:0];
                REG_STEP_LENGTH:   step_len = data[LEN_W-1:0];
                REG_BASE_VELOCITY: base_vel = data[VEL_W-1:0];
                REG_JITTER_AMOUNT: jitter   = data[VEL_W-1:0];
                default: ;
            endcase
        endfunction

        // bjorklund merge: head groups of A, tail groups of B
        function void lay_out();
            int n, k, heads, tails, len_a, len_b, m, new_tails, t, pos, guard, i, j;
            logic [STEP_CAP-1:0] grp_a, grp_b, held;
            n = span();
            k = int'(pulses);
            pattern = '0;
            grp_a = '0;
            grp_b = '0;
            if (k == 0) return;
            if (k >= n) begin
                for (i = 0; i < n; i++) pattern[i] = 1'b1;
                return;
            end
            heads = k;
            tails = n - k;
            grp_a[0] = 1'b1;
            len_a = 1;
            grp_b[0] = 1'b0;
            len_b = 1;
            for (guard = 0; tails > 1 && guard < STEP_CAP; guard++) begin
                m = (heads < tails) ? heads : tails;
                held = grp_a;
                for (j = 0; j < len_b; j++) begin
                    if (len_a + j < STEP_CAP) grp_a[len_a + j] = grp_b[j];
                end
                if (heads > m) begin
                    // leftover heads become the new tail group
                    new_tails = heads - m;
                    grp_b = held;
                    t = len_a;
                    len_a = len_a + len_b;
                    len_b = t;
                end else begin
                    new_tails = tails - m;
                    len_a = len_a + len_b;
                end
                heads = m;
                tails = new_tails;
            end
            pos = 0;
            for (i = 0; i < heads; i++) begin
                for (j = 0; j < len_a && pos < n; j++) begin
                    pattern[pos] = grp_a[j];
                    pos++;
                end
            end
            for (i = 0; i < tails; i++) begin
                for (j = 0; j < len_b && pos < n; j++) begin
                    pattern[pos] = grp_b[j];
                    pos++;
                end
            end
        endfunction

        function void note_word(logic op, logic [7:0] rv);
            t_step_word w;
            int n, pos, dev, v;
            w = '0;
            if (op == OP_REBUILD) begin
                lay_out();
                built  = 1;
                cursor = 0;
            end else begin
                n = span();
                pos = cursor;
                if (pos >= STEP_CAP) pos = STEP_CAP - 1;
                w.hit   = built && (pos < n) && pattern[pos];
                w.last  = (pos + 1 >= n);
                w.index = IDX_W'(pos);
                w.beat  = BEAT_W'(pos * int'(step_len));
                if (w.hit) begin
                    dev = (2 * int'(rv) - 256) * int'(jitter);
                    v = int'(base_vel) + (dev >>> 8);
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    w.velocity = VEL_W'(v);
                end
                cursor = w.last ? 0 : pos + 1;
            end
            due.insert(due.size(), w);
        endfunction

        function void check_step(logic hit, logic [IDX_W-1:0] index, logic [BEAT_W-1:0] beat,
                                 logic [VEL_W-1:0] velocity, logic last);
            t_step_word want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: hit %0d index %0d beat %0d vel %0d end %0d",
                             hit, index, beat, velocity, last);
                return;
            end
            want = due.pop_front();
            if (hit !== want.hit || index !== want.index || beat !== want.beat ||
                velocity !== want.velocity || last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  want: hit %0d index %0d beat %0d vel %0d end %0d",
                             want.hit, want.index, want.beat, want.velocity, want.last);
                    $display("  got:  hit %0d index %0d beat %0d vel %0d end %0d",
                             hit, index, beat, velocity, last);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_opcode = OP_REBUILD;
    logic [7:0]            i_random_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_hit;
    logic [IDX_W-1:0]      o_step_index;
    logic [BEAT_W-1:0]     o_beat_position;
    logic [VEL_W-1:0]      o_velocity_out;
    logic                  o_pattern_end;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_rhythm_book book = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycle_count = 0;

    euclidean_rhythm_sequencer #(
        .MAX_STEPS(STEP_CAP)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_random_value  (i_random_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_step_index    (o_step_index),
        .o_beat_position (o_beat_position),
        .o_velocity_out  (o_velocity_out),
        .o_pattern_end   (o_pattern_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // result checked before the new word is noted, in case both land on one edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                book.check_step(o_hit, o_step_index, o_beat_position, o_velocity_out,
                                o_pattern_end);
            if (i_valid && o_ready)
                book.note_word(i_opcode, i_random_value);
            if (i_cfg_valid && o_cfg_ready)
                book.set_reg(i_cfg_index, i_cfg_data);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // valid stays up after acceptance; the next word or a drain decides what follows
    task automatic send_word(input logic op, input logic [7:0] rv);
        if ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_random_value <= rv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // count registers, sometimes with junk above the used bits
    function automatic logic [CFG_DATA_W-1:0] count_data(int v);
        logic [CFG_DATA_W-1:0] d;
        d = '0;
        d[CNT_W-1:0] = v[CNT_W-1:0];
        if ($urandom_range(0, 1))
            d[CFG_DATA_W-1:CNT_W] = (CFG_DATA_W-CNT_W)'($urandom_range(0, 511));
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] level_data();
        logic [CFG_DATA_W-1:0] d;
        d = '0;
        case ($urandom_range(0, 3))
            0:       d[VEL_W-1:0] = '0;
            1:       d[VEL_W-1:0] = '1;
            default: d[VEL_W-1:0] = VEL_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 1))
            d[CFG_DATA_W-1:VEL_W] = (CFG_DATA_W-VEL_W)'($urandom_range(0, 255));
        return d;
    endfunction

    function automatic int pick_steps();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return STEP_CAP;
            2:       return 0;
            3:       return $urandom_range(STEP_CAP + 1, 127);
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    // fixed_steps below zero picks a random step count
    task automatic retune_all(input int fixed_steps);
        int n, eff, k;
        logic [LEN_W-1:0] len;
        n = (fixed_steps < 0) ? pick_steps() : fixed_steps;
        eff = (n == 0) ? 1 : ((n > STEP_CAP) ? STEP_CAP : n);
        case ($urandom_range(0, 5))
            0:       k = 0;
            1:       k = eff;
            2:       k = $urandom_range(eff, 127);
            default: k = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
        endcase
        case ($urandom_range(0, 3))
            0:       len = '0;
            1:       len = '1;
            default: len = LEN_W'($urandom_range(0, 65535));
        endcase
        cfg_write(REG_STEP_COUNT, count_data(n));
        cfg_write(REG_PULSE_COUNT, count_data(k));
        cfg_write(REG_STEP_LENGTH, CFG_DATA_W'(len));
        cfg_write(REG_BASE_VELOCITY, level_data());
        cfg_write(REG_JITTER_AMOUNT, level_data());
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int mode, phase, plays, k, pick, u;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_idle = 37;
        recv_idle = 51;

        // before any rebuild every step is a rest
        send_word(OP_PLAY, 8'h00);
        send_word(OP_PLAY, 8'hFF);
        send_word(OP_REBUILD, 8'h5A);
        send_word(OP_PLAY, 8'h00);
        send_word(OP_PLAY, 8'hFF);
        send_word(OP_PLAY, 8'h80);

        // zero step count acts as one step, full jitter around zero base
        drain();
        cfg_write(REG_JITTER_AMOUNT, CFG_DATA_W'(255));
        cfg_write(REG_BASE_VELOCITY, CFG_DATA_W'(0));
        cfg_write(REG_STEP_LENGTH, '1);
        cfg_write(REG_STEP_COUNT, CFG_DATA_W'(0));
        cfg_write(REG_PULSE_COUNT, CFG_DATA_W'(1));
        i_cfg_valid <= 1'b0;
        send_word(OP_REBUILD, 8'h00);
        send_word(OP_PLAY, 8'hFF);
        send_word(OP_PLAY, 8'h00);

        // oversized step count saturates, no pulses, unknown registers ignored
        drain();
        cfg_write(REG_STEP_COUNT, CFG_DATA_W'(100));
        cfg_write(REG_PULSE_COUNT, CFG_DATA_W'(0));
        cfg_write(REG_BASE_VELOCITY, CFG_DATA_W'(255));
        for (u = int'(REG_JITTER_AMOUNT) + 1; u < (1 << CFG_IDX_W); u++)
            cfg_write(CFG_IDX_W'(u), '1);
        i_cfg_valid <= 1'b0;
        send_word(OP_REBUILD, 8'hFF);
        send_word(OP_PLAY, 8'hFF);
        send_word(OP_PLAY, 8'h01);

        // step count shrinks under a built pattern
        drain();
        cfg_write(REG_STEP_COUNT, CFG_DATA_W'(5));
        cfg_write(REG_PULSE_COUNT, CFG_DATA_W'(3));
        i_cfg_valid <= 1'b0;
        send_word(OP_REBUILD, 8'h33);
        send_word(OP_PLAY, 8'hC0);
        send_word(OP_PLAY, 8'h40);
        send_word(OP_PLAY, 8'hFE);
        drain();
        cfg_write(REG_STEP_COUNT, CFG_DATA_W'(2));
        i_cfg_valid <= 1'b0;
        send_word(OP_PLAY, 8'h7F);
        send_word(OP_PLAY, 8'h81);

        // pulse count far above step count, clamping at both ends
        drain();
        cfg_write(REG_PULSE_COUNT, CFG_DATA_W'(127));
        cfg_write(REG_STEP_COUNT, CFG_DATA_W'(3));
        i_cfg_valid <= 1'b0;
        send_word(OP_REBUILD, 8'h00);
        send_word(OP_PLAY, 8'hFF);
        send_word(OP_PLAY, 8'h00);

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle = 37;
                    recv_idle = 51;
                end
                1: begin
                    send_idle = 51;
                    recv_idle = 37;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (phase = 0; phase < 6; phase++) begin
                drain();
                // first phase of each mode walks the full pattern to its last index
                if (phase == 0) begin
                    retune_all(STEP_CAP);
                    plays = STEP_CAP + 3;
                end else begin
                    retune_all(-1);
                    plays = $urandom_range(10, 24);
                end
                send_word(OP_REBUILD, 8'($urandom_range(0, 255)));
                for (k = 0; k < plays; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5) begin
                        send_word(OP_REBUILD, 8'($urandom_range(0, 255)));
                    end else if (pick < 8) begin
                        // retune mid pattern without a rebuild
                        drain();
                        case ($urandom_range(0, 3))
                            0: cfg_write(REG_STEP_COUNT, count_data(pick_steps()));
                            1: cfg_write(REG_PULSE_COUNT, count_data($urandom_range(0, 127)));
                            2: cfg_write(REG_STEP_LENGTH, CFG_DATA_W'($urandom_range(0, 65535)));
                            default: begin
                                cfg_write(REG_BASE_VELOCITY, level_data());
                                cfg_write(REG_JITTER_AMOUNT, level_data());
                            end
                        endcase
                        i_cfg_valid <= 1'b0;
                        send_word(OP_PLAY, 8'($urandom_range(0, 255)));
                    end else begin
                        send_word(OP_PLAY, 8'($urandom_range(0, 255)));
                    end
                end
            end
        end

        drain();
        repeat (TAIL) @(posedge i_clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
